@@ design/rcpc_pkg.sv @@
// Shared types and constants for the relay channel pulse controller.
// Used by the front decoder, the command queue, the back end and the top level.
package rcpc_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CHANNELS_DEF = 4;
    localparam int VIS_CHANNELS = 4;
    localparam int IDX_W        = 4;
    localparam int DUR_W        = 32;
    localparam int OP_W         = 3;
    localparam int CHAN_W       = 5;
    localparam int STATUS_W     = 2;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [OP_W-1:0] OP_SET     = 3'd0;
    localparam logic [OP_W-1:0] OP_TOGGLE  = 3'd1;
    localparam logic [OP_W-1:0] OP_PULSE   = 3'd2;
    localparam logic [OP_W-1:0] OP_GET     = 3'd3;
    localparam logic [OP_W-1:0] OP_ALL_OFF = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID_ARG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID_STATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIN_INVERT  = 1'd1;

    // Command class after decode; K_BAD covers every invalid_arg case
    typedef enum logic [2:0] {
        K_SET,
        K_TOGGLE,
        K_PULSE,
        K_GET,
        K_ALL_OFF,
        K_TICK,
        K_BAD
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] idx;
        logic             on_value;
        logic [DUR_W-1:0] duration;
    } cmd_t;

endpackage

@@ design/relay_channel_pulse_controller.sv @@
// Top level of the relay channel pulse controller: configuration registers and
// the front decoder, command queue and back end. Depends on rcpc_pkg.
//
// Usage:
//   Input stream (s_*): one request per command. s_tuser carries op (0 set,
//   1 toggle, 2 pulse, 3 get, 4 all off, 5 one-millisecond tick); s_tdata
//   carries channel (numbered from 1), on_value and the pulse duration.
//   Output stream (m_*): exactly one result request per command, in order,
//   with status, on_state, relay_states and drive_levels.
//   Config channel (cfg_*): index 0 writes channel_enable_mask, index 1 the
//   pin polarity (1 drives an on relay low); always ready, write only while
//   no command is in flight.
// Timing: an accepted command waits in the queue, and its result is registered
//   in the output register when the back end takes it; one command per cycle is
//   sustained while m_tready stays high, as all channels update together.
// Reset: all relays off, no pulses pending, enable mask 0, pin polarity 1.
// Stall: a held result stays in the output register; the two-entry queue
//   absorbs input until full, then s_tready drops.
module relay_channel_pulse_controller
    import rcpc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [OP_W-1:0]        s_tuser,   // [2:0] op
    input  logic [IN_DATA_W-1:0]   s_tdata,   // [4:0] channel, [5] on_value, [37:6] duration
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // [1:0] status, [2] on_state,
                                              // [6:3] relay_states, [10:7] drive_levels
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CFG_DATA_W-1:0] enable_mask_reg, enable_mask_next;
    logic                  pin_invert_reg, pin_invert_next;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        enable_mask_next = enable_mask_reg;
        pin_invert_next  = pin_invert_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ENABLE_MASK: enable_mask_next = cfg_data;
                REG_PIN_INVERT:  pin_invert_next  = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg <= '0;
            pin_invert_reg  <= 1'b1;
        end
        else
        begin
            enable_mask_reg <= enable_mask_next;
            pin_invert_reg  <= pin_invert_next;
        end
    end

    rcpc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    rcpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd)
    );

    rcpc_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (pop_valid),
        .cmd_ready   (pop_ready),
        .cmd         (pop_cmd),
        .enable_mask (enable_mask_reg),
        .pin_invert  (pin_invert_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ design/rcpc_front.sv @@
// Front end: accepts requests from the input stream and classifies them.
// Depends on rcpc_pkg; feeds rcpc_queue.
module rcpc_front
    import rcpc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [OP_W-1:0]       s_tuser,   // [2:0] op
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [4:0] channel, [5] on_value, [37:6] duration
    input  logic                  q_full,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic [CHAN_W-1:0] channel;
    logic [DUR_W-1:0]  duration;
    logic              chan_ok;

    assign channel  = s_tdata[CHAN_W-1:0];
    assign duration = s_tdata[CHAN_W+DUR_W:CHAN_W+1];
    assign chan_ok  = (channel != '0) && (channel <= CHAN_W'(CHANNELS));

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        push_cmd.idx      = IDX_W'(channel - CHAN_W'(1));
        push_cmd.on_value = s_tdata[CHAN_W];
        push_cmd.duration = duration;
        case (s_tuser)
            OP_SET:     push_cmd.kind = chan_ok ? K_SET : K_BAD;
            OP_TOGGLE:  push_cmd.kind = chan_ok ? K_TOGGLE : K_BAD;
            OP_PULSE:   push_cmd.kind = (chan_ok && duration != '0) ? K_PULSE : K_BAD;
            OP_GET:     push_cmd.kind = chan_ok ? K_GET : K_BAD;
            OP_ALL_OFF: push_cmd.kind = K_ALL_OFF;
            OP_TICK:    push_cmd.kind = K_TICK;
            default:    push_cmd.kind = K_BAD;
        endcase
    end

endmodule

@@ design/rcpc_queue.sv @@
// Short command queue between the front decoder and the back end.
// Depends on rcpc_pkg for the command type and depth.
module rcpc_queue
    import rcpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule

@@ design/rcpc_back.sv @@
// Back end: executes commands on the relay bank and pulse counters, registers the result.
// Depends on rcpc_pkg; takes commands from rcpc_queue.
module rcpc_back
    import rcpc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  cmd_t                   cmd,
    input  logic [CFG_DATA_W-1:0]  enable_mask,
    input  logic                   pin_invert,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    localparam int VIS = (CHANNELS < VIS_CHANNELS) ? CHANNELS : VIS_CHANNELS;
    localparam logic [VIS_CHANNELS-1:0] VIS_MASK = VIS_CHANNELS'((1 << VIS) - 1);

    logic [CHANNELS-1:0]     relay_reg, relay_next;
    logic [DUR_W-1:0]        pulse_reg  [CHANNELS];
    logic [DUR_W-1:0]        pulse_next [CHANNELS];
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    logic                    pop;
    logic [MAX_CHANNELS-1:0] mask_ext;
    logic [MAX_CHANNELS-1:0] relay_ext;
    logic [MAX_CHANNELS-1:0] relay_next_ext;
    logic [CHANNELS-1:0]     en_vec;
    logic                    sel_en;
    logic [STATUS_W-1:0]     status;
    logic                    on_state;
    logic [VIS_CHANNELS-1:0] states_vis;
    logic [VIS_CHANNELS-1:0] levels_vis;

    assign cmd_ready = !out_valid_reg || m_tready;
    assign pop       = cmd_valid && cmd_ready;

    assign mask_ext  = MAX_CHANNELS'(enable_mask);
    assign en_vec    = mask_ext[CHANNELS-1:0];
    assign relay_ext = MAX_CHANNELS'(relay_reg);
    assign sel_en    = mask_ext[cmd.idx];

    // Per-channel update; every channel is independent of the others
    always_comb
    begin
        relay_next = relay_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            pulse_next[i] = pulse_reg[i];
            case (cmd.kind)
                K_SET, K_TOGGLE:
                begin
                    if (cmd.idx == IDX_W'(i))
                    begin
                        pulse_next[i] = '0;
                        if (en_vec[i])
                        begin
                            relay_next[i] = (cmd.kind == K_SET) ? cmd.on_value : !relay_reg[i];
                        end
                    end
                end
                K_PULSE:
                begin
                    if (cmd.idx == IDX_W'(i) && en_vec[i])
                    begin
                        relay_next[i] = 1'b1;
                        pulse_next[i] = cmd.duration;
                    end
                end
                K_ALL_OFF:
                begin
                    if (en_vec[i])
                    begin
                        relay_next[i] = 1'b0;
                        pulse_next[i] = '0;
                    end
                end
                K_TICK:
                begin
                    if (pulse_reg[i] != '0)
                    begin
                        pulse_next[i] = pulse_reg[i] - DUR_W'(1);
                        // expiring count switches the relay off only while enabled
                        if (pulse_reg[i] == DUR_W'(1) && en_vec[i])
                        begin
                            relay_next[i] = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        status   = ST_OK;
        on_state = 1'b0;
        case (cmd.kind)
            K_SET, K_TOGGLE, K_PULSE:
            begin
                status = sel_en ? ST_OK : ST_INVALID_STATE;
            end
            K_GET:
            begin
                status   = sel_en ? ST_OK : ST_INVALID_STATE;
                on_state = sel_en && relay_ext[cmd.idx];
            end
            K_BAD:
            begin
                status = ST_INVALID_ARG;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign relay_next_ext = MAX_CHANNELS'(relay_next);
    assign states_vis     = relay_next_ext[VIS_CHANNELS-1:0] & VIS_MASK;
    assign levels_vis     = (relay_next_ext[VIS_CHANNELS-1:0] ^ {VIS_CHANNELS{pin_invert}})
                            & VIS_MASK;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'b0, levels_vis, states_vis, on_state, status};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pulse_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                relay_reg <= relay_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    pulse_reg[i] <= pulse_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("accepted command produced no result");

    a_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.kind == K_BAD) |=> out_data_reg[STATUS_W-1:0] == ST_INVALID_ARG)
        else $error("invalid command not reported as invalid_arg");

    a_pulse_on: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.kind == K_PULSE && sel_en) |=> relay_ext[$past(cmd.idx)])
        else $error("pulse did not switch relay on");

    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg[10:7] ==
            ((out_data_reg[6:3] ^ {VIS_CHANNELS{pin_invert}}) & VIS_MASK))
        else $error("drive levels disagree with relay states");

endmodule
